[design/cpf_pkg.sv]
// Shared beat types, constants and header builder for the column packet framer.
package cpf_pkg;

    localparam logic [15:0] KEEP_FULL = 16'hffff;
    localparam logic [15:0] KEEP_TAIL = 16'h00ff;
    localparam int          ID_W      = 5;

    typedef struct packed {
        logic [31:0] in_word3;
        logic [31:0] in_word2;
        logic [31:0] in_word1;
        logic [31:0] in_word0;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] out_word0;
        logic [31:0] out_word1;
        logic [31:0] out_word2;
        logic [31:0] out_word3;
        logic [15:0] byte_keep;
        logic        packet_last;
        logic        run_end;
    } t_out_beat;

    // One queued input transfer: its data beat and, on a column's last beat, its tail.
    typedef struct packed {
        logic [31:0] first_word;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] tail_word;
        logic        has_tail;
    } t_entry;

    // Header: id, type 0, all-ones source row and column, odd parity in bit 31.
    function automatic logic [31:0] make_header(input logic [ID_W-1:0] id);
        logic [30:0] low;
        low = {3'b000, 7'h7f, 5'h1f, 1'b0, 3'b000, 7'h00, id};
        return {~^low, low};
    endfunction

endpackage

[design/cpf_beat_queue.sv]
// Two-entry output queue that expands a column's last transfer into data and tail beats.
module cpf_beat_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cpf_pkg::t_entry    i_entry,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_ready,
    output cpf_pkg::t_out_beat o_beat
);
    import cpf_pkg::*;

    t_entry      r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        r_phase, n_phase;
    t_entry      head;
    logic        take;
    logic        pop;

    assign head    = r_mem[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign take    = o_valid && i_ready;
    // An entry with a tail leaves only after its second beat has been transferred.
    assign pop     = take && (r_phase || !head.has_tail);

    always_comb begin
        if (r_phase) begin
            o_beat.out_word0   = head.tail_word;
            o_beat.out_word1   = '0;
            o_beat.out_word2   = '0;
            o_beat.out_word3   = '0;
            o_beat.byte_keep   = KEEP_TAIL;
            o_beat.packet_last = 1'b1;
            o_beat.run_end     = 1'b1;
        end else begin
            o_beat.out_word0   = head.first_word;
            o_beat.out_word1   = head.word_a;
            o_beat.out_word2   = head.word_b;
            o_beat.out_word3   = head.word_c;
            o_beat.byte_keep   = KEEP_FULL;
            o_beat.packet_last = 1'b0;
            o_beat.run_end     = !head.has_tail;
        end
    end

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
        n_phase  = r_phase;
        if (take) begin
            n_phase = head.has_tail && !r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_phase  <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_phase  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[design/column_packet_framer.sv]
// Column packet framer: frames columns of 128-bit beats into headed packets with a tail beat.
// With the output queue empty, a beat's first result is offered in the cycle after
// its input transfer.
// Throughput: one input beat per cycle within a column while the output is ready; each column
// leaves as its data beats plus a tail beat, so the input stalls while its tail beat leaves.
// Input ready depends only on the two-entry output queue's fill, not on the output ready.
// Reset (synchronous, active low) clears the queue, beat counter, packet id and carry word.
module column_packet_framer #(
    parameter int COLUMN_WORDS      = 128,
    parameter int PACKETS_PER_BLOCK = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cpf_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cpf_pkg::t_out_beat o_out_data
);
    import cpf_pkg::*;

    localparam int BEATS  = (COLUMN_WORDS / 4 == 0) ? 1 : COLUMN_WORDS / 4;
    localparam int BEAT_W = (BEATS > 1) ? $clog2(BEATS) : 1;

    logic [BEAT_W-1:0] r_beat, n_beat;
    logic [ID_W-1:0]   r_pid, n_pid;
    logic [31:0]       r_carry, n_carry;
    logic              accept;
    logic              last_beat;
    logic              full;
    t_entry            entry;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;
    assign last_beat  = (r_beat == BEAT_W'(BEATS - 1));

    always_comb begin
        entry.first_word = (r_beat == '0) ? make_header(r_pid) : r_carry;
        entry.word_a     = i_in_data.in_word0;
        entry.word_b     = i_in_data.in_word1;
        entry.word_c     = i_in_data.in_word2;
        entry.tail_word  = i_in_data.in_word3;
        entry.has_tail   = last_beat;
    end

    always_comb begin
        n_beat  = r_beat;
        n_pid   = r_pid;
        n_carry = r_carry;
        if (accept) begin
            n_carry = i_in_data.in_word3;
            if (last_beat) begin
                n_beat = '0;
                n_pid  = (r_pid == ID_W'(PACKETS_PER_BLOCK - 1)) ? '0 : r_pid + 1'b1;
            end else begin
                n_beat = r_beat + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat  <= '0;
            r_pid   <= '0;
            r_carry <= '0;
        end else begin
            r_beat  <= n_beat;
            r_pid   <= n_pid;
            r_carry <= n_carry;
        end
    end

    cpf_beat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (entry),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_data)
    );

endmodule

[design/cpf_checker.sv]
// Port-level checks on the column packet framer, bound to its top level.
module cpf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input cpf_pkg::t_out_beat o_out_data
);
    import cpf_pkg::*;

    // A stalled output beat stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // The tail beat carries only the leftover word and always closes the run.
    a_tail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.packet_last |->
            o_out_data.run_end && o_out_data.byte_keep == KEEP_TAIL &&
            o_out_data.out_word1 == '0 && o_out_data.out_word2 == '0 &&
            o_out_data.out_word3 == '0)
        else $error("malformed tail beat");

    // Data beats are full width.
    a_data_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.packet_last |-> o_out_data.byte_keep == KEEP_FULL)
        else $error("data beat without full byte enables");

    // A data beat that does not end its run must be followed by the matching tail.
    a_tail_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.packet_last && !o_out_data.run_end
            |=> o_out_valid && o_out_data.packet_last)
        else $error("tail beat missing after last data beat");

endmodule

bind column_packet_framer cpf_checker u_cpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[dv/tb_column_packet_framer.sv]
// Self-checking testbench for column_packet_framer: directed, back-to-back and random beats.
module tb_column_packet_framer;
    import cpf_pkg::*;

    localparam int COLUMN_WORDS      = 128;
    localparam int PACKETS_PER_BLOCK = 8;
    localparam int BEATS_PER_COLUMN  = (COLUMN_WORDS / 4 == 0) ? 1 : COLUMN_WORDS / 4;
    localparam int RANDOM_BEATS      = 560;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_beat   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_beat  out_data;

    // Both sides stall at random only while this is set.
    bit         stalls_on = 1'b0;

    // Predictor state, kept in step with accepted input transfers.
    logic [31:0]  carried_word = '0;
    int unsigned  beat_pos     = 0;
    int unsigned  pkt_id       = 0;
    t_out_beat    expected_beats[$];

    int unsigned  n_beats_in  = 0;
    int unsigned  n_beats_out = 0;
    int unsigned  n_tails     = 0;
    int unsigned  n_errors    = 0;

    column_packet_framer #(
        .COLUMN_WORDS      (COLUMN_WORDS),
        .PACKETS_PER_BLOCK (PACKETS_PER_BLOCK)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Header: packet id in the low bits, all-ones source row and column, odd parity on top.
    function automatic logic [31:0] header_for(input int unsigned id);
        logic [31:0] hdr;
        hdr = 32'h0fff_0000 | (id & 32'h1f);
        hdr[31] = ($countones(hdr[30:0]) % 2 == 0);
        return hdr;
    endfunction

    // Works out the output beats that one accepted input beat causes.
    task automatic frame_beat(input t_in_beat b);
        t_out_beat   data_beat;
        t_out_beat   tail_beat;
        bit          closes_column;
        closes_column = (beat_pos + 1 >= BEATS_PER_COLUMN);
        data_beat.out_word0   = (beat_pos == 0) ? header_for(pkt_id) : carried_word;
        data_beat.out_word1   = b.in_word0;
        data_beat.out_word2   = b.in_word1;
        data_beat.out_word3   = b.in_word2;
        data_beat.byte_keep   = KEEP_FULL;
        data_beat.packet_last = 1'b0;
        data_beat.run_end     = !closes_column;
        expected_beats.push_back(data_beat);
        carried_word = b.in_word3;
        if (!closes_column) begin
            beat_pos++;
        end else begin
            tail_beat             = '0;
            tail_beat.out_word0   = carried_word;
            tail_beat.byte_keep   = KEEP_TAIL;
            tail_beat.packet_last = 1'b1;
            tail_beat.run_end     = 1'b1;
            expected_beats.push_back(tail_beat);
            beat_pos = 0;
            pkt_id   = (pkt_id + 1 >= PACKETS_PER_BLOCK) ? 0 : pkt_id + 1;
        end
    endtask

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // Offers one beat and holds it until the transfer happens; valid is left high for the next call.
    task automatic send_beat(input t_in_beat b);
        @(negedge clk);
        while (stalls_on && $urandom_range(0, 99) < 15) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = b;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        frame_beat(b);
        n_beats_in++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_beat random_beat();
        t_in_beat b;
        b.in_word0 = pick_word();
        b.in_word1 = pick_word();
        b.in_word2 = pick_word();
        b.in_word3 = pick_word();
        return b;
    endfunction

    // Word extremes and walking bits, so that every lane sees zeros, ones and single bits.
    task automatic test_word_extremes();
        t_in_beat b;
        stalls_on = 1'b1;
        send_beat('0);
        send_beat('1);
        send_beat({4{32'ha5a5_a5a5}});
        send_beat({4{32'h5a5a_5a5a}});
        send_beat({32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0});
        send_beat({32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff});
        for (int i = 0; i < 16; i++) begin
            b.in_word0 = 32'h1 << (2 * i);
            b.in_word1 = ~(32'h1 << (2 * i + 1));
            b.in_word2 = 32'h8000_0000 >> (2 * i);
            b.in_word3 = 32'h1 << (2 * i + 1);
            send_beat(b);
        end
    endtask

    // A long run with no stalls on either side, so tail beats meet a full input stream.
    task automatic test_back_to_back();
        stalls_on = 1'b0;
        for (int i = 0; i < 2 * BEATS_PER_COLUMN; i++) begin
            send_beat(random_beat());
        end
    endtask

    // Random content with random stalls, finishing on a column boundary.
    task automatic test_random_beats();
        int unsigned count;
        stalls_on = 1'b1;
        count = RANDOM_BEATS;
        while ((n_beats_in + count) % BEATS_PER_COLUMN != 0) begin
            count++;
        end
        for (int unsigned i = 0; i < count; i++) begin
            send_beat(random_beat());
        end
    endtask

    always @(negedge clk) begin
        out_ready = !(stalls_on && $urandom_range(0, 99) < 15);
    end

    // Each output transfer is compared with the oldest expected beat.
    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && out_valid && out_ready) begin
            n_beats_out++;
            if (out_data.packet_last) begin
                n_tails++;
            end
            if (expected_beats.size() == 0) begin
                note_error($sformatf("unexpected output beat %h", out_data));
            end else begin
                want = expected_beats.pop_front();
                if (out_data.out_word0 !== want.out_word0 ||
                    out_data.out_word1 !== want.out_word1 ||
                    out_data.out_word2 !== want.out_word2 ||
                    out_data.out_word3 !== want.out_word3 ||
                    out_data.byte_keep !== want.byte_keep ||
                    out_data.packet_last !== want.packet_last ||
                    out_data.run_end !== want.run_end) begin
                    note_error($sformatf(
                        "beat %0d: want %h %h %h %h %h %b %b, got %h %h %h %h %h %b %b",
                        n_beats_out, want.out_word0, want.out_word1, want.out_word2,
                        want.out_word3, want.byte_keep, want.packet_last, want.run_end,
                        out_data.out_word0, out_data.out_word1, out_data.out_word2,
                        out_data.out_word3, out_data.byte_keep, out_data.packet_last,
                        out_data.run_end));
                end
            end
        end
    end

    initial begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_word_extremes();
        test_back_to_back();
        test_random_beats();

        @(negedge clk);
        in_valid = 1'b0;
        while (expected_beats.size() != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Framed %0d input beats into %0d output beats, %0d of them tail beats.",
                 n_beats_in, n_beats_out, n_tails);
        $display("Packet ids wrapped over %0d ids with %0d beats per column; %0d errors.",
                 PACKETS_PER_BLOCK, BEATS_PER_COLUMN, n_errors);
        if (n_errors == 0) begin
            $display("tb_column_packet_framer: done, clean");
        end else begin
            $display("tb_column_packet_framer: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d output beats still expected.", expected_beats.size());
        $display("tb_column_packet_framer: done, errors");
        $finish;
    end

endmodule

[sim.f]
design/cpf_pkg.sv
design/cpf_beat_queue.sv
design/column_packet_framer.sv
design/cpf_checker.sv
dv/tb_column_packet_framer.sv
